// File: rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, constants and helpers for the touch report calibration block.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

    // field widths
    localparam int RAW_W     = 12;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 3;

    // divider bits resolved per pipeline stage
    localparam int DIV_BITS_PER_STAGE = 2;

    // default screen geometry
    localparam int DEF_SCREEN_WIDTH  = 480;
    localparam int DEF_SCREEN_HEIGHT = 320;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_X_MIN = 3'd0,
        CFG_CAL_X_MAX = 3'd1,
        CFG_CAL_Y_MIN = 3'd2,
        CFG_CAL_Y_MAX = 3'd3,
        CFG_INVERT_X  = 3'd4,
        CFG_INVERT_Y  = 3'd5,
        CFG_SWAP_XY   = 3'd6
    } cfg_index_t;

    // orientation controls applied in the merge stage
    typedef struct packed {
        logic invert_x;
        logic invert_y;
        logic swap_xy;
    } orient_t;

    // per-transaction sideband carried next to the lanes
    typedef struct packed {
        logic              pressed;
        logic [BYTE_W-1:0] pressure;
    } side_t;

    // number of divider stages needed for the larger screen axis
    function automatic int div_stages(input int width, input int height);
        int size_max;
        int num_w;
        size_max = (width > height) ? width : height;
        num_w    = RAW_W + $clog2(size_max + 1);
        return (num_w + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    endfunction

endpackage

`default_nettype wire

// File: rtl/trc_axis_lane.sv
// ----------------------------------------------------------------------------
// trc_axis_lane
// One axis of the mapping: scales the offset from the calibration minimum by
// the screen size, then divides by the calibration span in a pipelined
// restoring divider working on magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_axis_lane
    import trc_pkg::*;
#(
    parameter int SIZE       = DEF_SCREEN_WIDTH,
    parameter int DIV_STAGES = div_stages(DEF_SCREEN_WIDTH, DEF_SCREEN_HEIGHT),
    localparam int Q_W       = DIV_STAGES * DIV_BITS_PER_STAGE
)
(
    input  wire logic                  clk,
    input  wire logic [RAW_W-1:0]      raw,
    input  wire logic [RAW_W-1:0]      lo,
    input  wire logic [RAW_W-1:0]      hi,
    input  wire logic [DIV_STAGES:0]   load,
    output logic      [Q_W-1:0]        quot,
    output logic                       force_zero
);

    logic [RAW_W:0]   diff;
    logic [RAW_W:0]   span;
    logic [RAW_W-1:0] diff_mag;
    logic [RAW_W-1:0] span_mag;
    logic [Q_W-1:0]   prod;
    logic             fz;

    logic [Q_W-1:0]   work_reg [DIV_STAGES+1];
    logic [RAW_W-1:0] rem_reg  [DIV_STAGES+1];
    logic [RAW_W-1:0] den_reg  [DIV_STAGES+1];
    logic             fz_reg   [DIV_STAGES+1];

    // signed offset and span, reduced to magnitudes and a result sign
    always_comb
    begin
        diff     = {1'b0, raw} - {1'b0, lo};
        span     = {1'b0, hi} - {1'b0, lo};
        diff_mag = diff[RAW_W] ? RAW_W'(~diff + 1'b1) : diff[RAW_W-1:0];
        span_mag = span[RAW_W] ? RAW_W'(~span + 1'b1) : span[RAW_W-1:0];
        prod     = Q_W'(diff_mag) * Q_W'(SIZE);
        // negative quotient clamps to zero, zero span maps to zero
        fz       = (diff[RAW_W] ^ span[RAW_W]) || (span == '0);
    end

    // scale stage
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            work_reg[0] <= prod;
            rem_reg[0]  <= '0;
            den_reg[0]  <= span_mag;
            fz_reg[0]   <= fz;
        end
    end

    // divider stages, DIV_BITS_PER_STAGE (two) quotient bits each
    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        logic [RAW_W-1:0] rem_c;
        logic [Q_W-1:0]   work_c;
        logic [RAW_W:0]   trial;

        always_comb
        begin
            rem_c  = rem_reg[k-1];
            work_c = work_reg[k-1];
            trial  = '0;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++)
            begin
                trial = {rem_c, work_c[Q_W-1]};
                if (trial >= {1'b0, den_reg[k-1]})
                begin
                    trial  = trial - {1'b0, den_reg[k-1]};
                    work_c = {work_c[Q_W-2:0], 1'b1};
                end
                else
                begin
                    work_c = {work_c[Q_W-2:0], 1'b0};
                end
                rem_c = trial[RAW_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                work_reg[k] <= work_c;
                rem_reg[k]  <= rem_c;
                den_reg[k]  <= den_reg[k-1];
                fz_reg[k]   <= fz_reg[k-1];
            end
        end
    end

    assign quot       = work_reg[DIV_STAGES];
    assign force_zero = fz_reg[DIV_STAGES];

endmodule

`default_nettype wire

// File: rtl/trc_merge.sv
// ----------------------------------------------------------------------------
// trc_merge
// Combines the two axis lanes: clamps each quotient to the screen, applies
// mirroring and axis swap, zeroes a released point and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_merge
    import trc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int Q_W           = 24
)
(
    input  wire logic              clk,
    input  wire logic              load,
    input  wire logic [Q_W-1:0]    quot_x,
    input  wire logic              fz_x,
    input  wire logic [Q_W-1:0]    quot_y,
    input  wire logic              fz_y,
    input  wire side_t             side,
    input  wire orient_t           orient,
    output logic                   pressed,
    output logic [RAW_W-1:0]       screen_x,
    output logic [RAW_W-1:0]       screen_y,
    output logic [BYTE_W-1:0]      pressure
);

    localparam logic [RAW_W-1:0] W_LAST = RAW_W'(SCREEN_WIDTH - 1);
    localparam logic [RAW_W-1:0] H_LAST = RAW_W'(SCREEN_HEIGHT - 1);

    logic [RAW_W-1:0]  map_x;
    logic [RAW_W-1:0]  map_y;
    logic [RAW_W-1:0]  inv_x;
    logic [RAW_W-1:0]  inv_y;
    logic [RAW_W-1:0]  x_next;
    logic [RAW_W-1:0]  y_next;
    logic [BYTE_W-1:0] pres_next;

    logic              pressed_reg;
    logic [RAW_W-1:0]  x_reg;
    logic [RAW_W-1:0]  y_reg;
    logic [BYTE_W-1:0] pres_reg;

    // clamp to the screen
    always_comb
    begin
        if (fz_x)
            map_x = '0;
        else if (quot_x >= Q_W'(SCREEN_WIDTH))
            map_x = W_LAST;
        else
            map_x = quot_x[RAW_W-1:0];

        if (fz_y)
            map_y = '0;
        else if (quot_y >= Q_W'(SCREEN_HEIGHT))
            map_y = H_LAST;
        else
            map_y = quot_y[RAW_W-1:0];
    end

    // mirror, swap and release gating
    always_comb
    begin
        inv_x = orient.invert_x ? (W_LAST - map_x) : map_x;
        inv_y = orient.invert_y ? (H_LAST - map_y) : map_y;
        if (!side.pressed)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (orient.swap_xy)
        begin
            x_next = inv_y;
            y_next = inv_x;
        end
        else
        begin
            x_next = inv_x;
            y_next = inv_y;
        end
        pres_next = side.pressed ? side.pressure : '0;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pressed_reg <= side.pressed;
            x_reg       <= x_next;
            y_reg       <= y_next;
            pres_reg    <= pres_next;
        end
    end

    assign pressed  = pressed_reg;
    assign screen_x = x_reg;
    assign screen_y = y_reg;
    assign pressure = pres_reg;

endmodule

`default_nettype wire

// File: rtl/touch_report_calibrate.sv
// ----------------------------------------------------------------------------
// touch_report_calibrate
// Decodes a six-byte touch report and maps its point onto screen
// coordinates through per-axis calibration, mirroring and swap.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | read_ok, status_byte, x_high..pressure_byte
//  out     | out_valid/out_stall| pressed, screen_x, screen_y, pressure
//  cfg     | cfg_we             | cfg_index, cfg_data
//
//  One transaction per cycle sustained while out_stall is low; each passes
//  the scale stage, the divider stages of both axis lanes and the merge register.
//  Each stage advances on its own, so bubbles close up under out_stall and
//  input is taken until every stage holds a transaction.
//  rst_n clears valid flags and loads the calibration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_report_calibrate
    import trc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [RAW_W-1:0]     cfg_data,
    // report input
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 read_ok,
    input  wire logic [BYTE_W-1:0]    status_byte,
    input  wire logic [BYTE_W-1:0]    x_high,
    input  wire logic [BYTE_W-1:0]    x_low,
    input  wire logic [BYTE_W-1:0]    y_high,
    input  wire logic [BYTE_W-1:0]    y_low,
    input  wire logic [BYTE_W-1:0]    pressure_byte,
    // point output
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      pressed,
    output logic [RAW_W-1:0]          screen_x,
    output logic [RAW_W-1:0]          screen_y,
    output logic [BYTE_W-1:0]         pressure
);

    localparam int DIV_STAGES  = div_stages(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam int LANE_STAGES = DIV_STAGES + 1;
    localparam int Q_W         = DIV_STAGES * DIV_BITS_PER_STAGE;
    localparam int SIZE_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH
                                                                : SCREEN_HEIGHT;

    // configuration registers
    logic [RAW_W-1:0] cal_x_min_reg;
    logic [RAW_W-1:0] cal_x_max_reg;
    logic [RAW_W-1:0] cal_y_min_reg;
    logic [RAW_W-1:0] cal_y_max_reg;
    orient_t          orient_reg;

    // pipeline control
    logic [LANE_STAGES-1:0] valid_reg;
    logic                   out_valid_reg;
    logic [LANE_STAGES:0]   load;
    side_t                  side_in;
    side_t                  side_reg [LANE_STAGES];

    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [Q_W-1:0]   quot_x;
    logic [Q_W-1:0]   quot_y;
    logic             fz_x;
    logic             fz_y;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_x_min_reg <= '0;
            cal_x_max_reg <= '1;
            cal_y_min_reg <= '0;
            cal_y_max_reg <= '1;
            orient_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CAL_X_MIN: cal_x_min_reg       <= cfg_data;
                CFG_CAL_X_MAX: cal_x_max_reg       <= cfg_data;
                CFG_CAL_Y_MIN: cal_y_min_reg       <= cfg_data;
                CFG_CAL_Y_MAX: cal_y_max_reg       <= cfg_data;
                CFG_INVERT_X:  orient_reg.invert_x <= cfg_data[0];
                CFG_INVERT_Y:  orient_reg.invert_y <= cfg_data[0];
                CFG_SWAP_XY:   orient_reg.swap_xy  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // report field extraction
    assign raw_x            = {x_high[RAW_W-BYTE_W-1:0], x_low};
    assign raw_y            = {y_high[RAW_W-BYTE_W-1:0], y_low};
    assign side_in.pressed  = read_ok && (status_byte[COUNT_W-1:0] != '0);
    assign side_in.pressure = pressure_byte;

    // per-stage advance: a stage loads when empty or when the next one loads
    assign load[LANE_STAGES] = !out_valid_reg || !out_stall;
    for (genvar k = 0; k < LANE_STAGES; k++)
    begin : g_load
        assign load[k] = !valid_reg[k] || load[k+1];
    end
    assign in_stall = !load[0];

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < LANE_STAGES; k++)
            begin
                if (load[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
            if (load[LANE_STAGES])
                out_valid_reg <= valid_reg[LANE_STAGES-1];
        end
    end

    // sideband pipeline alongside the lanes
    always_ff @(posedge clk)
    begin
        if (load[0])
            side_reg[0] <= side_in;
        for (int k = 1; k < LANE_STAGES; k++)
        begin
            if (load[k])
                side_reg[k] <= side_reg[k-1];
        end
    end

    // axis lanes
    trc_axis_lane #(
        .SIZE       (SCREEN_WIDTH),
        .DIV_STAGES (DIV_STAGES)
    ) u_lane_x (
        .clk        (clk),
        .raw        (raw_x),
        .lo         (cal_x_min_reg),
        .hi         (cal_x_max_reg),
        .load       (load[LANE_STAGES-1:0]),
        .quot       (quot_x),
        .force_zero (fz_x)
    );

    trc_axis_lane #(
        .SIZE       (SCREEN_HEIGHT),
        .DIV_STAGES (DIV_STAGES)
    ) u_lane_y (
        .clk        (clk),
        .raw        (raw_y),
        .lo         (cal_y_min_reg),
        .hi         (cal_y_max_reg),
        .load       (load[LANE_STAGES-1:0]),
        .quot       (quot_y),
        .force_zero (fz_y)
    );

    // merge and output register
    trc_merge #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .Q_W           (Q_W)
    ) u_merge (
        .clk      (clk),
        .load     (load[LANE_STAGES]),
        .quot_x   (quot_x),
        .fz_x     (fz_x),
        .quot_y   (quot_y),
        .fz_y     (fz_y),
        .side     (side_reg[LANE_STAGES-1]),
        .orient   (orient_reg),
        .pressed  (pressed),
        .screen_x (screen_x),
        .screen_y (screen_y),
        .pressure (pressure)
    );

    assign out_valid = out_valid_reg;

    // input is held off only when every stage is occupied and the output waits
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg) && out_valid_reg && out_stall)
        else $error("input stalled with a free pipeline stage");

    // a released point carries no coordinates or pressure
    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pressed |-> screen_x == '0 && screen_y == '0 && pressure == '0)
        else $error("released point with nonzero payload");

    // pressed screen_x stays below the larger screen dimension
    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pressed |-> {1'b0, screen_x} < (RAW_W+1)'(SIZE_MAX))
        else $error("screen_x beyond screen");

endmodule

`default_nettype wire
